@@ rtl/mie_pkg.sv @@
// Shared types and constants for the modular inverse block.
package mie_pkg;

    // Modulus loaded at reset, before the width of the register is applied.
    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } mie_state_t;

endpackage

@@ rtl/mie_div.sv @@
// Serial restoring divider that also forms quotient times a signed coefficient.
module mie_div #(
    parameter int WIDTH = 31
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [WIDTH-1:0]        dividend,
    input  logic [WIDTH-1:0]        divisor,
    input  logic signed [WIDTH+1:0] coef,
    output logic                    done,
    output logic [WIDTH-1:0]        rem,
    output logic signed [WIDTH+2:0] prod
);
    import mie_pkg::*;

    localparam int SW = WIDTH + 2;
    localparam int PW = WIDTH + 3;
    localparam int CW = $clog2(WIDTH + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [WIDTH-1:0]     rem_reg, rem_next;
    logic [WIDTH-1:0]     dvd_reg, dvd_next;
    logic signed [PW-1:0] acc_reg, acc_next;

    logic [WIDTH:0]       rem_sh;
    logic                 ge;
    logic signed [PW-1:0] coef_ext;

    assign rem_sh   = {rem_reg, dvd_reg[WIDTH-1]};
    assign ge       = (rem_sh >= {1'b0, divisor});
    assign coef_ext = {{(PW-SW){coef[SW-1]}}, coef};

    // One quotient bit per cycle, most significant first. The product is
    // built by Horner's rule alongside, so no multiplier is needed.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(WIDTH);
            rem_next  = '0;
            dvd_next  = dividend;
            acc_next  = '0;
        end else if (busy_reg) begin
            rem_next = ge ? WIDTH'(rem_sh - {1'b0, divisor}) : rem_sh[WIDTH-1:0];
            dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
            acc_next = (acc_reg <<< 1) + (ge ? coef_ext : '0);
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign prod = acc_reg;

endmodule

@@ rtl/modular_inverse_ext_euclid_top.sv @@
// Top level: modular inverse and gcd by the extended Euclidean algorithm.
//
//   Channel   Dir  Handshake                Payload
//   s_        in   s_tvalid / s_tready      s_tdata: value
//   m_        out  m_tvalid / m_tready      m_tdata: inverse, common_divisor
//   cfg_      in   cfg_valid / cfg_ready    cfg_data: modulus
//
// Each Euclid step runs on the shared serial divider, sequenced by the CHECK,
// DIV and UPDATE states; after the last step the result is loaded in DONE,
// and only then does the input become ready again.
// The input is taken only when the sequencer is idle; a finished result waits
// in the output register while the next request is already accepted.
// Reset is synchronous and active low and loads the modulus 1000000007.
module modular_inverse_ext_euclid_top #(
    parameter int WIDTH = 31
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((WIDTH+7)/8)*8-1:0]        s_tdata,   // value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((2*WIDTH+7)/8)*8-1:0]      m_tdata,   // inverse, common_divisor
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [WIDTH-1:0]                  cfg_data   // modulus
);
    import mie_pkg::*;

    localparam int SW = WIDTH + 2;
    localparam int PW = WIDTH + 3;
    localparam int OW = ((2*WIDTH+7)/8)*8;

    mie_state_t state_reg, state_next;

    logic [WIDTH-1:0]     mod_reg;
    logic [WIDTH-1:0]     old_r_reg, old_r_next;
    logic [WIDTH-1:0]     r_reg, r_next;
    logic signed [SW-1:0] old_s_reg, old_s_next;
    logic signed [SW-1:0] s_reg, s_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WIDTH-1:0]     inv_reg, inv_next;
    logic [WIDTH-1:0]     gcd_reg, gcd_next;

    logic                 in_ready;
    logic                 div_start;
    logic                 load_out;
    logic                 div_done;
    logic [WIDTH-1:0]     div_rem;
    logic signed [PW-1:0] div_prod;
    logic signed [SW-1:0] mod_ext;
    logic signed [SW-1:0] fixed_s;
    logic [WIDTH-1:0]     inv_val;

    mie_div #(
        .WIDTH(WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (old_r_reg),
        .divisor  (r_reg),
        .coef     (s_reg),
        .done     (div_done),
        .rem      (div_rem),
        .prod     (div_prod)
    );

    // The final coefficient lies within one modulus of zero, so one
    // conditional add or subtract brings it into range.
    assign mod_ext = {2'b00, mod_reg};
    always_comb begin
        if (old_s_reg < 0) begin
            fixed_s = old_s_reg + mod_ext;
        end else if (old_s_reg >= mod_ext) begin
            fixed_s = old_s_reg - mod_ext;
        end else begin
            fixed_s = old_s_reg;
        end
    end
    assign inv_val = (mod_reg == '0) ? '0 : fixed_s[WIDTH-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_CHECK;
            ST_CHECK:  state_next = (r_reg == '0) ? ST_DONE : ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_CHECK;
            ST_DONE:   if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_CHECK:  div_start = (r_reg != '0);
            ST_DIV:    ;
            ST_UPDATE: ;
            ST_DONE:   load_out = !out_valid_reg || m_tready;
            default:   ;
        endcase
    end

    always_comb begin
        old_r_next = old_r_reg;
        r_next     = r_reg;
        old_s_next = old_s_reg;
        s_next     = s_reg;
        if (state_reg == ST_IDLE) begin
            old_r_next = s_tdata[WIDTH-1:0];
            r_next     = mod_reg;
            old_s_next = {{(SW-1){1'b0}}, 1'b1};
            s_next     = '0;
        end else if (state_reg == ST_UPDATE) begin
            old_r_next = r_reg;
            r_next     = div_rem;
            old_s_next = s_reg;
            s_next     = SW'({old_s_reg[SW-1], old_s_reg} - div_prod);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        inv_next       = inv_reg;
        gcd_next       = gcd_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (load_out) begin
            out_valid_next = 1'b1;
            inv_next       = inv_val;
            gcd_next       = old_r_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mod_reg       <= MODULUS_RESET[WIDTH-1:0];
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                mod_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        old_r_reg <= old_r_next;
        r_reg     <= r_next;
        old_s_reg <= old_s_next;
        s_reg     <= s_next;
        inv_reg   <= inv_next;
        gcd_reg   <= gcd_next;
    end

    assign s_tready  = in_ready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OW'({gcd_reg, inv_reg});

endmodule
